// File: rtl/voxel_grid_line_of_sight_unit_defines.svh
// Assertion macros used by the port checker of the line-of-sight unit
`ifndef VOXEL_GRID_LINE_OF_SIGHT_UNIT_DEFINES_SVH
`define VOXEL_GRID_LINE_OF_SIGHT_UNIT_DEFINES_SVH

// Check that cons holds whenever ante holds, outside reset
`define VGL_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cond holds at every clock edge outside reset
`define VGL_ASSERT_ALWAYS(label, cond, msg) \
	`VGL_ASSERT_IMP(label, 1'b1, cond, msg)

`endif

// File: rtl/vgl_pkg.sv
// Shared types, codes and constants of the voxel grid line-of-sight unit
package vgl_pkg;

	localparam int GRID_X_DEF = 64;
	localparam int GRID_Y_DEF = 64;
	localparam int GRID_Z_DEF = 32;

	localparam int COORD_W = 8;
	localparam int MAG_W   = 8;
	localparam int ACC_W   = 16;
	localparam int CELL_W  = 2;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_QUERY  = 2'd2,
		OP_UNUSED = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		QS_WALKED    = 2'd0,
		QS_NOT_READY = 2'd1,
		QS_RANGE     = 2'd2,
		QS_UNUSED    = 2'd3
	} qstatus_t;

	localparam logic [CELL_W-1:0] CELL_UNKNOWN  = 2'd0;
	localparam logic [CELL_W-1:0] CELL_FREE     = 2'd1;
	localparam logic [CELL_W-1:0] CELL_OCCUPIED = 2'd2;

	localparam logic [7:0] FREE_MAX_INTENSITY = 8'd25;
	localparam logic [7:0] OCC_MIN_INTENSITY  = 8'd231;

	// One boundary-time comparison: is axis a's next crossing strictly earlier than b's
	typedef struct packed {
		logic [MAG_W-1:0] mag_a;
		logic [MAG_W-1:0] mag_b;
		logic [ACC_W-1:0] acc_ab;
		logic [ACC_W-1:0] acc_ba;
	} tcmp_req_t;

	function automatic logic [MAG_W-1:0] mag_of(input logic [COORD_W:0] d);
		logic [COORD_W:0] n;
		n = -d;
		return d[COORD_W] ? n[MAG_W-1:0] : d[MAG_W-1:0];
	endfunction

endpackage

// File: rtl/voxel_grid_line_of_sight_unit.sv
// Top level of the voxel grid line-of-sight unit: sequencer, cell store and walk datapath
//
// An item is taken when start is high and busy is low. Point updates and clears give
// no result. A query gives one result, shown on visible and query_status while done
// is high for exactly one cycle; the receiver cannot hold it off. A rejected query, or
// one whose start equals its end, answers in the cycle after the transfer. A walked
// query visits up to |dx|+|dy|+|dz|+1 cells; for each cell the read state reads the cell
// store while the shared comparator weighs x against y, and the compare state uses the
// read data and weighs the winner against z. Its result is registered when the walk
// reaches the end cell or an occupied cell. After reset the cell store is swept to
// unknown, one cell a cycle, all 2^(clog2(GRID_X)+clog2(GRID_Y)+clog2(GRID_Z)) cells
// (131072 at the default sizes), with busy high; register writes are taken throughout.
module voxel_grid_line_of_sight_unit #(
	parameter int GRID_X = vgl_pkg::GRID_X_DEF,
	parameter int GRID_Y = vgl_pkg::GRID_Y_DEF,
	parameter int GRID_Z = vgl_pkg::GRID_Z_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [7:0]  start_x,
	input  logic [7:0]  start_y,
	input  logic [7:0]  start_z,
	input  logic [7:0]  end_x,
	input  logic [7:0]  end_y,
	input  logic [7:0]  end_z,
	input  logic [7:0]  intensity,
	output logic        done,
	output logic        visible,
	output logic [1:0]  query_status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int XW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
	localparam int YW    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
	localparam int ZW    = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
	localparam int AW    = XW + YW + ZW;
	localparam int DEPTH = 1 << AW;
	localparam int CW    = vgl_pkg::COORD_W;
	localparam int MW    = vgl_pkg::MAG_W;
	localparam int AC    = vgl_pkg::ACC_W;
	localparam logic [CW:0] GX = (CW+1)'(GRID_X);
	localparam logic [CW:0] GY = (CW+1)'(GRID_Y);
	localparam logic [CW:0] GZ = (CW+1)'(GRID_Z);

	typedef enum logic [3:0] {
		S_CLR  = 4'b0001,
		S_IDLE = 4'b0010,
		S_RD   = 4'b0100,
		S_CMP  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic                grid_ready_q;
	logic                done_q;
	logic                visible_q;
	logic [1:0]          status_q;

	logic [XW-1:0]       cur_x_q, end_x_q;
	logic [YW-1:0]       cur_y_q, end_y_q;
	logic [ZW-1:0]       cur_z_q, end_z_q;
	logic                neg_x_q, neg_y_q, neg_z_q;
	logic [MW-1:0]       mag_x_q, mag_y_q, mag_z_q;
	logic [AC-1:0]       acc_xy_q, acc_yx_q, acc_xz_q, acc_zx_q, acc_yz_q, acc_zy_q;
	logic                c1_q;

	logic                accept, cfg_wr;
	logic                s_in, e_in, same;
	logic                is_low, is_high;
	logic [CW:0]         dx, dy, dz;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [vgl_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
	vgl_pkg::tcmp_req_t  creq;
	logic                less;
	logic                hit_end, occ;
	logic                ax_x, ax_y, ax_z;
	logic                fin_early, fin_walk;

	function automatic logic coord_ok(input logic [CW-1:0] c, input logic [CW:0] lim);
		return !c[CW-1] && ({1'b0, c} < lim);
	endfunction

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {31'd0, grid_ready_q};

	assign s_in = coord_ok(start_x, GX) && coord_ok(start_y, GY) && coord_ok(start_z, GZ);
	assign e_in = coord_ok(end_x, GX) && coord_ok(end_y, GY) && coord_ok(end_z, GZ);
	assign same = (start_x == end_x) && (start_y == end_y) && (start_z == end_z);

	assign is_low  = intensity <= vgl_pkg::FREE_MAX_INTENSITY;
	assign is_high = intensity >= vgl_pkg::OCC_MIN_INTENSITY;

	assign dx = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
	assign dy = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
	assign dz = {end_z[CW-1], end_z} - {start_z[CW-1], start_z};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {start_z[ZW-1:0], start_y[YW-1:0], start_x[XW-1:0]};
		ram_wdata = vgl_pkg::CELL_UNKNOWN;
		if (state_q == S_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end else if (accept && grid_ready_q && s_in) begin
			if (opcode == vgl_pkg::OP_CLEAR) begin
				ram_we = 1'b1;
			end else if (opcode == vgl_pkg::OP_UPDATE && (is_low || is_high)) begin
				ram_we    = 1'b1;
				ram_wdata = is_low ? vgl_pkg::CELL_FREE : vgl_pkg::CELL_OCCUPIED;
			end
		end
	end

	assign ram_raddr = {cur_z_q, cur_y_q, cur_x_q};

	vgl_ram #(
		.WIDTH(vgl_pkg::CELL_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (state_q == S_RD) begin
			creq = '{mag_a: mag_x_q, mag_b: mag_y_q, acc_ab: acc_xy_q, acc_ba: acc_yx_q};
		end else if (c1_q) begin
			creq = '{mag_a: mag_x_q, mag_b: mag_z_q, acc_ab: acc_xz_q, acc_ba: acc_zx_q};
		end else begin
			creq = '{mag_a: mag_y_q, mag_b: mag_z_q, acc_ab: acc_yz_q, acc_ba: acc_zy_q};
		end
	end

	vgl_tcmp u_tcmp (
		.req (creq),
		.less(less)
	);

	assign hit_end = (cur_x_q == end_x_q) && (cur_y_q == end_y_q) && (cur_z_q == end_z_q);
	assign occ     = (ram_rdata == vgl_pkg::CELL_OCCUPIED);
	assign ax_x    = c1_q && less;
	assign ax_y    = !c1_q && less;
	assign ax_z    = !less;

	assign fin_early = (state_q == S_IDLE) && accept && (opcode == vgl_pkg::OP_QUERY) &&
		(!grid_ready_q || !s_in || !e_in || same);
	assign fin_walk  = (state_q == S_CMP) && (hit_end || occ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			grid_ready_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= fin_early || fin_walk;
			if (cfg_wr && !paddr[2]) begin
				grid_ready_q <= pwdata[0];
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == {AW{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && opcode == vgl_pkg::OP_QUERY && !fin_early) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (fin_walk) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept && opcode == vgl_pkg::OP_QUERY) begin
					if (!grid_ready_q) begin
						visible_q <= 1'b0;
						status_q  <= vgl_pkg::QS_NOT_READY;
					end else if (!s_in || !e_in) begin
						visible_q <= 1'b0;
						status_q  <= vgl_pkg::QS_RANGE;
					end else begin
						visible_q <= same;
						status_q  <= vgl_pkg::QS_WALKED;
					end
					cur_x_q  <= start_x[XW-1:0];
					cur_y_q  <= start_y[YW-1:0];
					cur_z_q  <= start_z[ZW-1:0];
					end_x_q  <= end_x[XW-1:0];
					end_y_q  <= end_y[YW-1:0];
					end_z_q  <= end_z[ZW-1:0];
					neg_x_q  <= dx[CW];
					neg_y_q  <= dy[CW];
					neg_z_q  <= dz[CW];
					mag_x_q  <= vgl_pkg::mag_of(dx);
					mag_y_q  <= vgl_pkg::mag_of(dy);
					mag_z_q  <= vgl_pkg::mag_of(dz);
					acc_xy_q <= AC'(vgl_pkg::mag_of(dy));
					acc_xz_q <= AC'(vgl_pkg::mag_of(dz));
					acc_yx_q <= AC'(vgl_pkg::mag_of(dx));
					acc_yz_q <= AC'(vgl_pkg::mag_of(dz));
					acc_zx_q <= AC'(vgl_pkg::mag_of(dx));
					acc_zy_q <= AC'(vgl_pkg::mag_of(dy));
				end
			end
			S_RD: begin
				c1_q <= less;
			end
			S_CMP: begin
				if (hit_end || occ) begin
					visible_q <= hit_end;
					status_q  <= vgl_pkg::QS_WALKED;
				end else begin
					// advance along the axis whose boundary comes first
					if (ax_x) begin
						cur_x_q  <= cur_x_q + (neg_x_q ? {XW{1'b1}} : XW'(1));
						acc_xy_q <= acc_xy_q + AC'(mag_y_q);
						acc_xz_q <= acc_xz_q + AC'(mag_z_q);
					end
					if (ax_y) begin
						cur_y_q  <= cur_y_q + (neg_y_q ? {YW{1'b1}} : YW'(1));
						acc_yx_q <= acc_yx_q + AC'(mag_x_q);
						acc_yz_q <= acc_yz_q + AC'(mag_z_q);
					end
					if (ax_z) begin
						cur_z_q  <= cur_z_q + (neg_z_q ? {ZW{1'b1}} : ZW'(1));
						acc_zx_q <= acc_zx_q + AC'(mag_x_q);
						acc_zy_q <= acc_zy_q + AC'(mag_y_q);
					end
				end
			end
			default: begin
				c1_q <= c1_q;
			end
		endcase
	end

	assign done         = done_q;
	assign visible      = visible_q;
	assign query_status = status_q;

endmodule

// File: rtl/vgl_ram.sv
// Generic single-write, single-read RAM with registered read data
module vgl_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/vgl_tcmp.sv
// Shared boundary-time comparator of the voxel walk
module vgl_tcmp (
	input  vgl_pkg::tcmp_req_t req,
	output logic               less
);

	always_comb begin
		if (req.mag_a == '0) begin
			less = 1'b0;
		end else if (req.mag_b == '0) begin
			less = 1'b1;
		end else begin
			less = req.acc_ab < req.acc_ba;
		end
	end

endmodule

// File: rtl/vgl_chk.sv
// Port checker of the voxel grid line-of-sight unit and its bind
`include "voxel_grid_line_of_sight_unit_defines.svh"

module vgl_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       visible,
	input logic [1:0] query_status,
	input logic       pready
);

	`VGL_ASSERT_IMP(a_done_has_cause, done, $past(busy || start), "result without a transfer or walk")
	`VGL_ASSERT_IMP(a_reject_not_visible, done && query_status != vgl_pkg::QS_WALKED, !visible, "rejected query shown visible")
	`VGL_ASSERT_IMP(a_status_code, done, query_status != vgl_pkg::QS_UNUSED, "unused query status code")
	`VGL_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule

bind voxel_grid_line_of_sight_unit vgl_chk u_vgl_chk (.*);

// File: verif/tb_top.sv
// Self-checking testbench of the voxel grid line-of-sight unit: random and directed commands
module tb_top;
	import vgl_pkg::*;

	localparam int GRID_X = GRID_X_DEF;
	localparam int GRID_Y = GRID_Y_DEF;
	localparam int GRID_Z = GRID_Z_DEF;
	localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
	localparam int BOX_XY = 12;
	localparam int BOX_Z = 8;
	localparam int WATCHDOG_LIMIT = 1 << 19;
	localparam logic [2:0] REG_GRID_READY = 3'd0;

	typedef struct packed {
		opcode_t op;
		logic [7:0] sx;
		logic [7:0] sy;
		logic [7:0] sz;
		logic [7:0] ex;
		logic [7:0] ey;
		logic [7:0] ez;
		logic [7:0] inten;
	} ray_cmd_t;

	typedef struct packed {
		logic vis;
		qstatus_t status;
	} sight_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] opcode = 2'd0;
	logic [7:0] start_x = 8'd0;
	logic [7:0] start_y = 8'd0;
	logic [7:0] start_z = 8'd0;
	logic [7:0] end_x = 8'd0;
	logic [7:0] end_y = 8'd0;
	logic [7:0] end_z = 8'd0;
	logic [7:0] intensity = 8'd0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	wire busy;
	wire done;
	wire visible;
	wire [1:0] query_status;
	wire [31:0] prdata;
	wire pready;

	logic [1:0] occ_map [CELLS];
	logic grid_on;
	ray_cmd_t pend_q [$];
	sight_t sight_q [$];
	ray_cmd_t cur_cmd;
	logic nxt_start;
	int gap_left = 0;
	int burst_left = 0;
	int fails = 0;
	int idle_cycles;

	voxel_grid_line_of_sight_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.start_x(start_x),
		.start_y(start_y),
		.start_z(start_z),
		.end_x(end_x),
		.end_y(end_y),
		.end_z(end_z),
		.intensity(intensity),
		.done(done),
		.visible(visible),
		.query_status(query_status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit in_bounds(int x, int y, int z);
		return x >= 0 && x < GRID_X && y >= 0 && y < GRID_Y && z >= 0 && z < GRID_Z;
	endfunction

	function automatic int cell_at(int x, int y, int z);
		return x + GRID_X * (y + GRID_Y * z);
	endfunction

	// strictly earlier next boundary crossing of axis a than of axis b
	function automatic bit earlier(int mag_a, int cnt_a, int mag_b, int cnt_b);
		if (mag_a == 0)
			return 1'b0;
		if (mag_b == 0)
			return 1'b1;
		return (cnt_a + 1) * mag_b < (cnt_b + 1) * mag_a;
	endfunction

	function automatic bit trace_ray(input int s[3], input int e[3]);
		int cur[3];
		int mag[3];
		int stp[3];
		int cnt[3];
		int lim;
		int ax;
		int idx;
		int end_idx;
		if (s[0] == e[0] && s[1] == e[1] && s[2] == e[2])
			return 1'b1;
		for (int i = 0; i < 3; i++) begin
			cur[i] = s[i];
			mag[i] = (e[i] >= s[i]) ? e[i] - s[i] : s[i] - e[i];
			stp[i] = (e[i] > s[i]) ? 1 : ((e[i] < s[i]) ? -1 : 0);
			cnt[i] = 0;
		end
		end_idx = cell_at(e[0], e[1], e[2]);
		lim = mag[0] + mag[1] + mag[2] + 1;
		for (int n = 0; n < lim; n++) begin
			if (!in_bounds(cur[0], cur[1], cur[2]))
				return 1'b0;
			idx = cell_at(cur[0], cur[1], cur[2]);
			if (occ_map[idx] == CELL_OCCUPIED && idx != end_idx)
				return 1'b0;
			if (idx == end_idx)
				return 1'b1;
			if (earlier(mag[0], cnt[0], mag[1], cnt[1]))
				ax = earlier(mag[0], cnt[0], mag[2], cnt[2]) ? 0 : 2;
			else
				ax = earlier(mag[1], cnt[1], mag[2], cnt[2]) ? 1 : 2;
			cur[ax] += stp[ax];
			cnt[ax] += 1;
		end
		return 1'b0;
	endfunction

	function automatic void predict_sight(ray_cmd_t c);
		int s[3];
		int e[3];
		int idx;
		sight_t r;
		s[0] = int'($signed(c.sx));
		s[1] = int'($signed(c.sy));
		s[2] = int'($signed(c.sz));
		e[0] = int'($signed(c.ex));
		e[1] = int'($signed(c.ey));
		e[2] = int'($signed(c.ez));
		case (c.op)
			OP_UPDATE, OP_CLEAR: begin
				if (grid_on && in_bounds(s[0], s[1], s[2])) begin
					idx = cell_at(s[0], s[1], s[2]);
					if (c.op == OP_CLEAR)
						occ_map[idx] = CELL_UNKNOWN;
					else if (c.inten <= FREE_MAX_INTENSITY)
						occ_map[idx] = CELL_FREE;
					else if (c.inten >= OCC_MIN_INTENSITY)
						occ_map[idx] = CELL_OCCUPIED;
				end
			end
			OP_QUERY: begin
				r.vis = 1'b0;
				if (!grid_on)
					r.status = QS_NOT_READY;
				else if (!in_bounds(s[0], s[1], s[2]) || !in_bounds(e[0], e[1], e[2]))
					r.status = QS_RANGE;
				else begin
					r.vis = trace_ray(s, e);
					r.status = QS_WALKED;
				end
				sight_q.insert(sight_q.size(), r);
			end
			default: ;
		endcase
	endfunction

	function automatic ray_cmd_t mk(opcode_t op, int sx, int sy, int sz, int ex, int ey, int ez,
			int inten);
		ray_cmd_t c;
		c.op = op;
		c.sx = 8'(sx);
		c.sy = 8'(sy);
		c.sz = 8'(sz);
		c.ex = 8'(ex);
		c.ey = 8'(ey);
		c.ez = 8'(ez);
		c.inten = 8'(inten);
		return c;
	endfunction

	function automatic void enqueue(ray_cmd_t c);
		pend_q.insert(pend_q.size(), c);
	endfunction

	function automatic logic [7:0] pick(int hi);
		return 8'($urandom_range(hi));
	endfunction

	function automatic ray_cmd_t rand_cmd();
		ray_cmd_t c;
		int r;
		int k;
		int j;
		c = mk(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		r = $urandom_range(99);
		k = $urandom_range(99);
		if (r < 40)
			c.op = OP_UPDATE;
		else if (r < 50)
			c.op = OP_CLEAR;
		else if (r < 92)
			c.op = OP_QUERY;
		else begin
			c.op = opcode_t'($urandom_range(3));
			return c;
		end
		if (c.op != OP_QUERY) begin
			if (k < 85) begin
				c.sx = pick(BOX_XY - 1);
				c.sy = pick(BOX_XY - 1);
				c.sz = pick(BOX_Z - 1);
			end else if (k < 97) begin
				c.sx = pick(GRID_X - 1);
				c.sy = pick(GRID_Y - 1);
				c.sz = pick(GRID_Z - 1);
			end
			j = $urandom_range(9);
			if (j < 4)
				c.inten = 8'($urandom_range(FREE_MAX_INTENSITY));
			else if (j < 8)
				c.inten = 8'($urandom_range(255, OCC_MIN_INTENSITY));
		end else if (k < 95) begin
			if (k < 70) begin
				c.sx = pick(BOX_XY - 1);
				c.sy = pick(BOX_XY - 1);
				c.sz = pick(BOX_Z - 1);
				c.ex = pick(BOX_XY - 1);
				c.ey = pick(BOX_XY - 1);
				c.ez = pick(BOX_Z - 1);
			end else begin
				c.sx = pick(GRID_X - 1);
				c.sy = pick(GRID_Y - 1);
				c.sz = pick(GRID_Z - 1);
				c.ex = pick(GRID_X - 1);
				c.ey = pick(GRID_Y - 1);
				c.ez = pick(GRID_Z - 1);
			end
			if (k >= 90) begin
				c.ex = c.sx;
				c.ey = c.sy;
				c.ez = c.sz;
			end
		end else begin
			c.sx = pick(GRID_X - 1);
			c.sy = pick(GRID_Y - 1);
			c.sz = pick(GRID_Z - 1);
			c.ex = pick(GRID_X - 1);
			c.ey = pick(GRID_Y - 1);
			c.ez = pick(GRID_Z - 1);
			case ($urandom_range(5))
				0: c.sx = 8'($urandom);
				1: c.sy = 8'($urandom);
				2: c.sz = 8'($urandom);
				3: c.ex = 8'($urandom);
				4: c.ey = 8'($urandom);
				default: c.ez = 8'($urandom);
			endcase
		end
		return c;
	endfunction

	function automatic int next_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 5) begin
			burst_left = $urandom_range(30, 10);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(20, 4);
		return $urandom_range(300, 50);
	endfunction

	task automatic set_grid_ready(logic v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_GRID_READY;
		pwdata <= {31'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		grid_on = v;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== {31'd0, v}) begin
			$error("grid_ready: expected %0d, actual %0d", v, prdata);
			fails++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// hold until every command is taken and every result is back, then let the block settle
	task automatic drain();
		do
			@(posedge clk);
		while (pend_q.size() != 0 || start || sight_q.size() != 0 || busy);
		repeat (16) @(posedge clk);
	endtask

	task automatic push_random(int n);
		repeat (n) enqueue(rand_cmd());
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			nxt_start = start;
			if (start && !busy) begin
				predict_sight(cur_cmd);
				nxt_start = 1'b0;
				gap_left = next_gap();
			end
			if (!nxt_start) begin
				if (gap_left > 0)
					gap_left--;
				else if (pend_q.size() != 0) begin
					cur_cmd = pend_q.pop_front();
					opcode <= cur_cmd.op;
					start_x <= cur_cmd.sx;
					start_y <= cur_cmd.sy;
					start_z <= cur_cmd.sz;
					end_x <= cur_cmd.ex;
					end_y <= cur_cmd.ey;
					end_z <= cur_cmd.ez;
					intensity <= cur_cmd.inten;
					nxt_start = 1'b1;
				end
			end
			start <= nxt_start;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (sight_q.size() == 0) begin
				$error("done: result with none expected");
				fails++;
			end else begin
				if (visible !== sight_q[0].vis) begin
					$error("visible: expected %0d, actual %0d", sight_q[0].vis, visible);
					fails++;
				end
				if (query_status !== sight_q[0].status) begin
					$error("query_status: expected %0d, actual %0d", sight_q[0].status,
						query_status);
					fails++;
				end
				void'(sight_q.pop_front());
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done || (psel && penable && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		for (int i = 0; i < CELLS; i++)
			occ_map[i] = CELL_UNKNOWN;
		grid_on = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		set_grid_ready(1'b0);
		enqueue(mk(OP_QUERY, 2, 3, 4, 9, 9, 9, 0));
		enqueue(mk(OP_UPDATE, 0, 0, 0, 0, 0, 0, 255));
		enqueue(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		enqueue(mk(OP_QUERY, -128, 0, 0, 127, 0, 0, 0));
		enqueue(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
		drain();

		set_grid_ready(1'b1);
		enqueue(mk(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0));
		enqueue(mk(OP_UPDATE, 63, 63, 31, 0, 0, 0, 255));
		enqueue(mk(OP_UPDATE, 1, 1, 1, 0, 0, 0, 231));
		enqueue(mk(OP_UPDATE, 2, 2, 2, 0, 0, 0, 230));
		enqueue(mk(OP_UPDATE, 3, 3, 3, 0, 0, 0, 25));
		enqueue(mk(OP_UPDATE, 4, 4, 4, 0, 0, 0, 26));
		enqueue(mk(OP_UPDATE, 64, 0, 0, 0, 0, 0, 255));
		enqueue(mk(OP_UPDATE, -1, 5, 5, 0, 0, 0, 255));
		enqueue(mk(OP_CLEAR, 5, 5, 32, 0, 0, 0, 0));
		enqueue(mk(OP_UNUSED, -1, -1, -1, -1, -1, -1, 255));
		enqueue(mk(OP_QUERY, 63, 63, 31, 63, 63, 31, 0));
		enqueue(mk(OP_QUERY, 1, 1, 1, 5, 5, 5, 0));
		enqueue(mk(OP_QUERY, 0, 0, 0, 63, 63, 31, 0));
		enqueue(mk(OP_QUERY, -1, 0, 0, 5, 5, 5, 0));
		enqueue(mk(OP_QUERY, 0, 0, 0, 0, 0, 32, 0));
		enqueue(mk(OP_QUERY, 0, 0, 0, 0, 64, 0, 0));
		enqueue(mk(OP_UPDATE, 10, 0, 0, 0, 0, 0, 255));
		enqueue(mk(OP_QUERY, 0, 0, 0, 20, 0, 0, 0));
		enqueue(mk(OP_CLEAR, 10, 0, 0, 0, 0, 0, 0));
		enqueue(mk(OP_QUERY, 0, 0, 0, 20, 0, 0, 0));
		enqueue(mk(OP_QUERY, 0, 0, 0, 3, 3, 3, 0));
		enqueue(mk(OP_QUERY, 62, 63, 31, 0, 0, 0, 0));
		enqueue(mk(OP_QUERY, 63, 0, 31, 0, 63, 0, 0));
		drain();

		push_random(300);
		drain();

		set_grid_ready(1'b0);
		push_random(30);
		drain();

		set_grid_ready(1'b1);
		push_random(220);
		drain();

		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
